/* rtl/assert_macros.svh */
// Assertion macros used by the sequencer top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define HVPS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define HVPS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle implication check failed");

`endif

/* rtl/hvps_pkg.sv */
// Types and constants shared by the precharge and ready-to-drive sequencer.
package hvps_pkg;

  localparam int VOLT_W   = 16;
  localparam int TIME_W   = 32;
  localparam int TICK_W   = 16;
  localparam int TARGET_W = 10;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [VOLT_W-1:0] PACK_MIN_DECIVOLTS = 16'd100;
  localparam logic [TIME_W-1:0] SHUTDOWN_DWELL_MS  = 32'd500;

  // Register reset values.
  localparam logic [15:0]         RST_RISE_DELAY = 16'd500;
  localparam logic [15:0]         RST_MIN_RISE   = 16'd100;
  localparam logic [TARGET_W-1:0] RST_TARGET     = 10'd950;
  localparam logic [15:0]         RST_TIMEOUT    = 16'd5000;
  localparam logic [15:0]         RST_BUZZER     = 16'd2000;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_RISE_DELAY = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_RISE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TARGET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BUZZER     = 3'd4;

  // Vehicle operating modes.
  typedef enum logic [2:0] {
    MODE_INIT  = 3'd0,
    MODE_LV    = 3'd1,
    MODE_PRE   = 3'd2,
    MODE_HV    = 3'd3,
    MODE_WAIT  = 3'd4,
    MODE_DRIVE = 3'd5,
    MODE_FAULT = 3'd6,
    MODE_SHUT  = 3'd7
  } mode_t;

  localparam logic [1:0] SEV_LIMP     = 2'd2;
  localparam logic [1:0] SEV_CRITICAL = 2'd3;

  typedef struct packed {
    logic [TICK_W-1:0] tick_ms;
    logic [1:0]        worst_severity;
    logic              battery_link_ok;
    logic              inverter_link_ok;
    logic              hv_request;
    logic              safety_loop_closed;
    logic              ready_button;
    logic              brake_pressed;
    logic [VOLT_W-1:0] link_decivolts;
    logic [VOLT_W-1:0] pack_decivolts;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       neg_contactor;
    logic       pos_contactor;
    logic       precharge_relay_on;
    logic       buzzer_on;
    logic       shutdown_drive;
    logic       inverter_on;
    logic       no_rise_fault;
    logic       timeout_fault;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic compute;
    logic commit;
  } hvps_cmd_t;

  // Controller sequencing states.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_MUL  = 3'b010,
    ST_UPD  = 3'b100
  } ctrl_state_t;

endpackage

/* rtl/hvps_ctrl.sv */
// Controller that sequences one tick through capture, multiply and commit.
module hvps_ctrl
  import hvps_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output hvps_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic        slot_free;

  // The result register can take a new value when empty or being emptied.
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.compute = 1'b1;
        state_nxt   = ST_UPD;
      end
      ST_UPD: begin
        if (slot_free) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Result valid flag: set by a commit, cleared by a transfer.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/hvps_dp.sv */
// Datapath: configuration, mode state, timers, fill-ratio products and result register.
module hvps_dp
  import hvps_pkg::*;
#(
  parameter int FULL_SCALE_PERMILLE = 1000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  hvps_cmd_t             cmd,
  input  in_item_t              in_item,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  output out_item_t             out_item
);

  localparam int FS_W   = $clog2(FULL_SCALE_PERMILLE + 1);
  localparam int LINK_W = VOLT_W + FS_W;
  localparam int PACK_W = VOLT_W + TARGET_W;
  localparam int PROD_W = (LINK_W > PACK_W) ? LINK_W : PACK_W;
  localparam logic [FS_W-1:0] FS_K = FS_W'(FULL_SCALE_PERMILLE);

  // Configuration registers.
  logic [15:0]         rise_delay_r;
  logic [15:0]         min_rise_r;
  logic [TARGET_W-1:0] target_r;
  logic [15:0]         timeout_r;
  logic [15:0]         buzzer_r;

  // Architectural state.
  mode_t             mode_r, mode_nxt;
  logic              just_entered_r, just_entered_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [VOLT_W-1:0] start_v_r, start_v_nxt;
  logic              rise_checked_r, rise_checked_nxt;
  logic [TIME_W-1:0] hold_r, hold_nxt;

  // Captured item and intermediate results.
  in_item_t          item_r;
  logic [TIME_W-1:0] time_sum_r, time_sum_nxt;
  logic [TIME_W-1:0] hold_sum_r, hold_sum_nxt;
  logic [PROD_W-1:0] link_prod_r, pack_prod_r;
  out_item_t         out_r, out_nxt;

  logic [TIME_W:0]   time_wide, hold_wide;
  logic              links_ok, fill_ok, no_rise, tmo, do_enter, rc_used;
  logic [VOLT_W-1:0] now_v, start_used;
  mode_t             tgt;

  assign out_item = out_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rise_delay_r <= RST_RISE_DELAY;
      min_rise_r   <= RST_MIN_RISE;
      target_r     <= RST_TARGET;
      timeout_r    <= RST_TIMEOUT;
      buzzer_r     <= RST_BUZZER;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RISE_DELAY: rise_delay_r <= cfg_wdata;
        CFG_MIN_RISE:   min_rise_r   <= cfg_wdata;
        CFG_TARGET:     target_r     <= cfg_wdata[TARGET_W-1:0];
        CFG_TIMEOUT:    timeout_r    <= cfg_wdata;
        CFG_BUZZER:     buzzer_r     <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Saturating timer sums for the compute cycle.
  always_comb begin
    time_wide    = {1'b0, time_r} + (TIME_W + 1)'(item_r.tick_ms);
    hold_wide    = {1'b0, hold_r} + (TIME_W + 1)'(item_r.tick_ms);
    time_sum_nxt = time_wide[TIME_W] ? '1 : time_wide[TIME_W-1:0];
    hold_sum_nxt = hold_wide[TIME_W] ? '1 : hold_wide[TIME_W-1:0];
  end

  // Capture the item, then register the two cross products of the fill test.
  // floor(link * FS / pack) >= target holds exactly when link * FS >= target * pack.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item_r <= in_item;
    end
    if (cmd.compute) begin
      time_sum_r  <= time_sum_nxt;
      hold_sum_r  <= hold_sum_nxt;
      link_prod_r <= PROD_W'(item_r.link_decivolts) * PROD_W'(FS_K);
      pack_prod_r <= PROD_W'(item_r.pack_decivolts) * PROD_W'(target_r);
    end
  end

  // Mode step, applied on commit.
  always_comb begin
    mode_nxt         = mode_r;
    just_entered_nxt = 1'b0;
    time_nxt         = time_sum_r;
    start_v_nxt      = start_v_r;
    rise_checked_nxt = rise_checked_r;
    hold_nxt         = hold_r;
    no_rise          = 1'b0;
    tmo              = 1'b0;
    do_enter         = 1'b0;
    tgt              = mode_r;

    links_ok   = item_r.battery_link_ok && item_r.inverter_link_ok;
    now_v      = item_r.inverter_link_ok ? item_r.link_decivolts : '0;
    start_used = just_entered_r ? now_v : start_v_r;
    rc_used    = just_entered_r ? 1'b0 : rise_checked_r;
    // An unusable ratio counts as zero, which passes only a zero target.
    if (!links_ok || (item_r.pack_decivolts < PACK_MIN_DECIVOLTS)) begin
      fill_ok = (target_r == '0);
    end else begin
      fill_ok = (link_prod_r >= pack_prod_r);
    end

    if ((item_r.worst_severity == SEV_CRITICAL) && (mode_r != MODE_FAULT) &&
        (mode_r != MODE_SHUT)) begin
      do_enter = 1'b1;
      tgt      = MODE_FAULT;
    end else begin
      unique case (mode_r)
        MODE_INIT: begin
          if (links_ok) begin
            do_enter = 1'b1;
            tgt      = MODE_LV;
          end
        end
        MODE_LV: begin
          if (item_r.hv_request && item_r.safety_loop_closed &&
              (item_r.worst_severity < SEV_LIMP)) begin
            do_enter = 1'b1;
            tgt      = MODE_PRE;
          end
        end
        MODE_PRE: begin
          start_v_nxt      = start_used;
          rise_checked_nxt = rc_used;
          if (!rc_used && (time_sum_r >= TIME_W'(rise_delay_r))) begin
            rise_checked_nxt = 1'b1;
            no_rise = ({1'b0, now_v} < ({1'b0, start_used} + {1'b0, min_rise_r}));
          end
          if (fill_ok) begin
            do_enter = 1'b1;
            tgt      = MODE_HV;
          end else if (time_sum_r >= TIME_W'(timeout_r)) begin
            tmo = 1'b1;
          end
          // A dropped request wins over reaching HV active on the same tick.
          if (!item_r.hv_request) begin
            do_enter = 1'b1;
            tgt      = MODE_LV;
          end
        end
        MODE_HV: begin
          do_enter = 1'b1;
          tgt      = item_r.hv_request ? MODE_WAIT : MODE_SHUT;
        end
        MODE_WAIT: begin
          if (!item_r.hv_request) begin
            do_enter = 1'b1;
            tgt      = MODE_SHUT;
          end else if (item_r.brake_pressed && item_r.ready_button) begin
            if (hold_sum_r >= TIME_W'(buzzer_r)) begin
              hold_nxt = '0;
              do_enter = 1'b1;
              tgt      = MODE_DRIVE;
            end else begin
              hold_nxt = hold_sum_r;
            end
          end else begin
            hold_nxt = '0;
          end
        end
        MODE_DRIVE: begin
          if (!item_r.hv_request) begin
            do_enter = 1'b1;
            tgt      = MODE_SHUT;
          end
        end
        MODE_FAULT: begin
          if ((item_r.worst_severity != SEV_CRITICAL) && !item_r.hv_request) begin
            do_enter = 1'b1;
            tgt      = MODE_LV;
          end
        end
        MODE_SHUT: begin
          if (time_sum_r > SHUTDOWN_DWELL_MS) begin
            do_enter = 1'b1;
            tgt      = MODE_LV;
          end
        end
        default: ;
      endcase
    end

    // Moving to a different mode restarts the mode timer.
    if (do_enter && (tgt != mode_r)) begin
      mode_nxt         = tgt;
      just_entered_nxt = 1'b1;
      time_nxt         = '0;
    end

    // Drives follow the mode after the step.
    out_nxt.mode               = mode_nxt;
    out_nxt.neg_contactor      = (mode_nxt == MODE_PRE) || (mode_nxt == MODE_HV) ||
                                 (mode_nxt == MODE_WAIT) || (mode_nxt == MODE_DRIVE);
    out_nxt.pos_contactor      = (mode_nxt == MODE_HV) || (mode_nxt == MODE_WAIT) ||
                                 (mode_nxt == MODE_DRIVE);
    out_nxt.precharge_relay_on = (mode_nxt == MODE_PRE);
    out_nxt.buzzer_on          = (mode_nxt == MODE_WAIT) && (hold_nxt != '0);
    out_nxt.shutdown_drive     = (mode_nxt == MODE_FAULT);
    out_nxt.inverter_on        = (mode_nxt == MODE_DRIVE);
    out_nxt.no_rise_fault      = no_rise;
    out_nxt.timeout_fault      = tmo;
  end

  // State update on commit.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= MODE_INIT;
      just_entered_r <= 1'b1;
      time_r         <= '0;
      start_v_r      <= '0;
      rise_checked_r <= 1'b0;
      hold_r         <= '0;
    end else if (cmd.commit) begin
      mode_r         <= mode_nxt;
      just_entered_r <= just_entered_nxt;
      time_r         <= time_nxt;
      start_v_r      <= start_v_nxt;
      rise_checked_r <= rise_checked_nxt;
      hold_r         <= hold_nxt;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= out_nxt;
    end
  end

endmodule

/* rtl/hv_precharge_ready_to_drive_sequencer.sv */
// Top level of the HV precharge and ready-to-drive sequencer.
// Each tick is captured, multiplied and then committed to the registered result.
// A new tick is taken only once the previous one has been committed.
// A result that is not taken holds the commit, and with it the next tick transfer.
// Synchronous active-low reset returns to init mode, clears the timers and reloads registers.
`include "assert_macros.svh"

module hv_precharge_ready_to_drive_sequencer
  import hvps_pkg::*;
#(
  parameter int FULL_SCALE_PERMILLE = 1000
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_item,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_item,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  hvps_cmd_t cmd;

  // Register writes are always taken.
  assign cfg_ready = 1'b1;

  hvps_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  hvps_dp #(
    .FULL_SCALE_PERMILLE (FULL_SCALE_PERMILLE)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
    ,
    .out_item  (out_item)
  );

  // Only one tick is in flight: a transfer closes the input until commit.
  `HVPS_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)
  // The positive contactor never closes without the negative one.
  `HVPS_ASSERT_IMP(a_contactor_order, out_valid && out_item.pos_contactor,
                   out_item.neg_contactor)
  // The inverter is enabled only with both contactors closed.
  `HVPS_ASSERT_IMP(a_inverter_hv, out_valid && out_item.inverter_on,
                   out_item.pos_contactor && out_item.neg_contactor)
  // A timeout is flagged only on a tick that stays in precharge or drops back to LV ready.
  `HVPS_ASSERT_IMP(a_timeout_mode, out_valid && out_item.timeout_fault,
                   (out_item.mode == MODE_PRE) || (out_item.mode == MODE_LV))

endmodule
